// File: sv/idri_pkg.sv
// ----------------------------------------------------------------------------
// idri_pkg
// Types, widths and the control store of the IMU dead-reckoning integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package idri_pkg;

	// Field and state widths.
	localparam int STAMP_W = 32;
	localparam int IMU_W   = 16;
	localparam int ST_W    = 48;
	localparam int IN_W    = STAMP_W + 3 * IMU_W;
	localparam int OUT_W   = 4 * ST_W;

	// Datapath widths.
	localparam int MUL_W   = 32;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int CHUNK_W = 16;
	localparam int ACC_W   = ST_W + STAMP_W;
	localparam int SUM_W   = ST_W + 4;
	localparam int EMAG_W  = 31;
	localparam int ROOT_W  = 32;
	localparam int REM_W   = ROOT_W + 2;
	localparam int CNT_W   = $clog2(ROOT_W);
	localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);

	// Microprogram addresses.
	localparam int UADDR_W = 5;
	typedef logic [UADDR_W-1:0] uaddr_t;

	localparam uaddr_t UA_IDLE = uaddr_t'(0);
	localparam uaddr_t UA_WZ   = uaddr_t'(1);
	localparam uaddr_t UA_HEAD = uaddr_t'(2);
	localparam uaddr_t UA_VX   = uaddr_t'(3);
	localparam uaddr_t UA_VY   = uaddr_t'(4);
	localparam uaddr_t UA_LOOP = uaddr_t'(5);
	localparam uaddr_t UA_M2   = uaddr_t'(6);
	localparam uaddr_t UA_M1   = uaddr_t'(7);
	localparam uaddr_t UA_M0   = uaddr_t'(8);
	localparam uaddr_t UA_ACC  = uaddr_t'(9);
	localparam uaddr_t UA_POS  = uaddr_t'(10);
	localparam uaddr_t UA_STEP = uaddr_t'(11);
	localparam uaddr_t UA_EX   = uaddr_t'(12);
	localparam uaddr_t UA_EY   = uaddr_t'(13);
	localparam uaddr_t UA_SQ   = uaddr_t'(14);
	localparam uaddr_t UA_SQRT = uaddr_t'(15);
	localparam uaddr_t UA_DIST = uaddr_t'(16);
	localparam uaddr_t UA_EMIT = uaddr_t'(17);

	// Operand pair fed to the shared multiplier.
	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_WZ,
		MUL_AX,
		MUL_AY,
		MUL_M2,
		MUL_M1,
		MUL_M0,
		MUL_EX,
		MUL_EY
	} mul_sel_t;

	// Datapath operation of one step.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_HEAD,
		OP_VX,
		OP_VY,
		OP_LDMAG,
		OP_ACC,
		OP_POS,
		OP_STEP,
		OP_SQLD,
		OP_SQADD,
		OP_SQRT,
		OP_DIST,
		OP_EMIT
	} op_t;

	// Sequencing of one step.
	typedef enum logic [2:0] {
		BR_NEXT,
		BR_JUMP,
		BR_START,
		BR_AXIS,
		BR_CNT,
		BR_EMIT
	} br_t;

	typedef struct packed {
		mul_sel_t mul;
		op_t      op;
		br_t      br;
		uaddr_t   target;
	} uword_t;

	function automatic uword_t mk_uword(input mul_sel_t mul, input op_t op, input br_t br,
			input uaddr_t target);
		uword_t w;
		w.mul    = mul;
		w.op     = op;
		w.br     = br;
		w.target = target;
		return w;
	endfunction

	// Control store. The position loop runs twice, once per axis, and the
	// square-root step repeats on itself until the iteration count is spent.
	function automatic uword_t ucode(input uaddr_t a);
		uword_t w;
		case (a)
			UA_IDLE: w = mk_uword(MUL_NONE, OP_NOP,   BR_START, UA_WZ);
			UA_WZ:   w = mk_uword(MUL_WZ,   OP_NOP,   BR_NEXT,  UA_IDLE);
			UA_HEAD: w = mk_uword(MUL_AX,   OP_HEAD,  BR_NEXT,  UA_IDLE);
			UA_VX:   w = mk_uword(MUL_AY,   OP_VX,    BR_NEXT,  UA_IDLE);
			UA_VY:   w = mk_uword(MUL_NONE, OP_VY,    BR_NEXT,  UA_IDLE);
			UA_LOOP: w = mk_uword(MUL_NONE, OP_LDMAG, BR_NEXT,  UA_IDLE);
			UA_M2:   w = mk_uword(MUL_M2,   OP_NOP,   BR_NEXT,  UA_IDLE);
			UA_M1:   w = mk_uword(MUL_M1,   OP_ACC,   BR_NEXT,  UA_IDLE);
			UA_M0:   w = mk_uword(MUL_M0,   OP_ACC,   BR_NEXT,  UA_IDLE);
			UA_ACC:  w = mk_uword(MUL_NONE, OP_ACC,   BR_NEXT,  UA_IDLE);
			UA_POS:  w = mk_uword(MUL_NONE, OP_POS,   BR_NEXT,  UA_IDLE);
			UA_STEP: w = mk_uword(MUL_NONE, OP_STEP,  BR_AXIS,  UA_LOOP);
			UA_EX:   w = mk_uword(MUL_EX,   OP_NOP,   BR_NEXT,  UA_IDLE);
			UA_EY:   w = mk_uword(MUL_EY,   OP_SQLD,  BR_NEXT,  UA_IDLE);
			UA_SQ:   w = mk_uword(MUL_NONE, OP_SQADD, BR_NEXT,  UA_IDLE);
			UA_SQRT: w = mk_uword(MUL_NONE, OP_SQRT,  BR_CNT,   UA_SQRT);
			UA_DIST: w = mk_uword(MUL_NONE, OP_DIST,  BR_NEXT,  UA_IDLE);
			UA_EMIT: w = mk_uword(MUL_NONE, OP_EMIT,  BR_EMIT,  UA_IDLE);
			default: w = mk_uword(MUL_NONE, OP_NOP,   BR_JUMP,  UA_IDLE);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// File: sv/imu_dead_reckoning_integrator_core.sv
// ----------------------------------------------------------------------------
// imu_dead_reckoning_integrator_core
// Euler dead reckoning of heading, velocity, position and distance from IMU.
// ----------------------------------------------------------------------------
// Each input transaction carries one IMU sample: a time stamp (2^-20 s),
// forward and leftward acceleration (2^-10 m/s2) and yaw rate (2^-12 rad/s).
// The first sample after reset only records its stamp and produces no output
// transaction. Every later sample takes dt as the stamp difference modulo
// 2^32, integrates heading (wrapping), velocity and then position (both
// saturating, body frame, no rotation), and adds the floor square root of the
// squared per-step displacement (2^-16 m, each axis capped at 2^31 - 1) to a
// saturating total distance. It then emits one output transaction with
// position, heading and total distance. The control store walks one 32 x 32
// multiplier through the products (position needs three 16-bit slices of the
// velocity per axis) and then runs a restoring square root at one result bit
// per cycle. Results sit in an output register, so the next sample is
// accepted while the previous result still waits; the block stalls only when
// a second result is ready before the first has been taken.
`default_nettype none

module imu_dead_reckoning_integrator_core (
	input  wire          clk,
	input  wire          arst_n,
	// Input sample. tdata fields from bit 0: stamp[31:0], accel_x[15:0],
	// accel_y[15:0], yaw_rate[15:0].
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [79:0]  s_axis_tdata,
	// Result. tdata fields from bit 0: pos_x_out[47:0], pos_y_out[47:0],
	// heading_out[47:0], distance_out[47:0].
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [191:0] m_axis_tdata
);

	localparam int ST_W   = idri_pkg::ST_W;
	localparam int IMU_W  = idri_pkg::IMU_W;
	localparam int ACC_W  = idri_pkg::ACC_W;
	localparam int SUM_W  = idri_pkg::SUM_W;
	localparam int PROD_W = idri_pkg::PROD_W;
	localparam int MUL_W  = idri_pkg::MUL_W;
	localparam int ROOT_W = idri_pkg::ROOT_W;
	localparam int REM_W  = idri_pkg::REM_W;
	localparam int EMAG_W = idri_pkg::EMAG_W;
	localparam int CK_W   = idri_pkg::CHUNK_W;

	// Signed saturation of a wide sum to 48 bits.
	function automatic logic [ST_W-1:0] sat48(input logic [SUM_W-1:0] v);
		logic [SUM_W-ST_W:0] top;
		top = v[SUM_W-1:ST_W-1];
		if (top == '0 || top == '1) begin
			return v[ST_W-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(ST_W-1){1'b0}}};
		end else begin
			return {1'b0, {(ST_W-1){1'b1}}};
		end
	endfunction

	function automatic logic [IMU_W-1:0] abs16(input logic [IMU_W-1:0] v);
		return v[IMU_W-1] ? IMU_W'(-v) : v;
	endfunction

	// Input field views.
	logic [idri_pkg::STAMP_W-1:0] in_stamp;
	logic [IMU_W-1:0]             in_ax, in_ay, in_wz;
	assign in_stamp = s_axis_tdata[31:0];
	assign in_ax    = s_axis_tdata[47:32];
	assign in_ay    = s_axis_tdata[63:48];
	assign in_wz    = s_axis_tdata[79:64];

	// Sequencer.
	idri_pkg::uaddr_t ua_q, ua_d;
	idri_pkg::uword_t uw;
	assign uw = idri_pkg::ucode(ua_q);

	// Control and architectural state.
	logic                         seen_first_q;
	logic [idri_pkg::STAMP_W-1:0] prior_q;
	logic [ST_W-1:0]              vel_x_q, vel_y_q, pos_x_q, pos_y_q, heading_q, dist_q;
	logic                         axis_q;
	logic [idri_pkg::CNT_W-1:0]   cnt_q;
	logic                         out_valid_q;

	// Datapath registers.
	logic [idri_pkg::STAMP_W-1:0] dt_q;
	logic [IMU_W-1:0]             ax_q, ay_q, wz_q;
	logic [PROD_W-1:0]            prod_q;
	logic                         prod_neg_q;
	logic [ST_W-1:0]              mag_q;
	logic                         mag_neg_q;
	logic [ACC_W-1:0]             acc_q;
	logic [ST_W-1:0]              oldp_q;
	logic [EMAG_W-1:0]            ex_q, ey_q;
	logic [PROD_W-1:0]            sqn_q;
	logic [REM_W-1:0]             rem_q;
	logic [ROOT_W-1:0]            root_q;
	logic [ST_W-1:0]              out_px_q, out_py_q, out_hd_q, out_ds_q;

	// Handshake decode.
	logic in_acc, out_free, emit_en;

	always_comb begin
		s_axis_tready = (ua_q == idri_pkg::UA_IDLE);
		in_acc        = s_axis_tvalid && s_axis_tready;
		out_free      = !out_valid_q || m_axis_tready;
		emit_en       = (uw.op == idri_pkg::OP_EMIT) && out_free;
	end

	// Next microprogram address.
	always_comb begin
		case (uw.br)
			idri_pkg::BR_NEXT:  ua_d = ua_q + idri_pkg::uaddr_t'(1);
			idri_pkg::BR_JUMP:  ua_d = uw.target;
			idri_pkg::BR_START: ua_d = (in_acc && seen_first_q) ? uw.target : ua_q;
			idri_pkg::BR_AXIS:  ua_d = !axis_q ? uw.target : ua_q + idri_pkg::uaddr_t'(1);
			idri_pkg::BR_CNT:   ua_d = (cnt_q != '0) ? uw.target : ua_q + idri_pkg::uaddr_t'(1);
			idri_pkg::BR_EMIT:  ua_d = out_free ? uw.target : ua_q;
			default:            ua_d = idri_pkg::UA_IDLE;
		endcase
	end

	// Multiplier operand selection. Signed factors enter as magnitudes; the
	// sign travels beside the registered product.
	logic [MUL_W-1:0] mul_a, mul_b;
	logic             mul_neg;

	always_comb begin
		mul_a   = '0;
		mul_b   = dt_q;
		mul_neg = 1'b0;
		case (uw.mul)
			idri_pkg::MUL_WZ: begin
				mul_a   = MUL_W'(abs16(wz_q));
				mul_neg = wz_q[IMU_W-1];
			end
			idri_pkg::MUL_AX: begin
				mul_a   = MUL_W'(abs16(ax_q));
				mul_neg = ax_q[IMU_W-1];
			end
			idri_pkg::MUL_AY: begin
				mul_a   = MUL_W'(abs16(ay_q));
				mul_neg = ay_q[IMU_W-1];
			end
			idri_pkg::MUL_M2: mul_a = MUL_W'(mag_q[3*CK_W-1:2*CK_W]);
			idri_pkg::MUL_M1: mul_a = MUL_W'(mag_q[2*CK_W-1:CK_W]);
			idri_pkg::MUL_M0: mul_a = MUL_W'(mag_q[CK_W-1:0]);
			idri_pkg::MUL_EX: begin
				mul_a = MUL_W'(ex_q);
				mul_b = MUL_W'(ex_q);
			end
			idri_pkg::MUL_EY: begin
				mul_a = MUL_W'(ey_q);
				mul_b = MUL_W'(ey_q);
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	// Arithmetic around the state registers.
	logic [ST_W:0]      sprod;        // signed rate or acceleration times dt
	logic [SUM_W-1:0]   vx_sum, vy_sum;
	logic [ST_W-1:0]    vel_sel, pos_sel, pos_new;
	logic [SUM_W-1:0]   pos_dlt, pos_sum;
	logic [ST_W:0]      disp, disp_mag;
	logic [ST_W-4:0]    disp_sh;
	logic [EMAG_W-1:0]  emag;
	logic [REM_W+1:0]   sq_rem, sq_trial;
	logic               sq_take;
	logic [ST_W:0]      dist_sum;

	always_comb begin
		sprod = prod_neg_q ? (ST_W+1)'(-{1'b0, prod_q[ST_W-1:0]})
		                   : {1'b0, prod_q[ST_W-1:0]};
		vx_sum = {{(SUM_W-ST_W){vel_x_q[ST_W-1]}}, vel_x_q}
		       + {{(SUM_W-ST_W-1){sprod[ST_W]}}, sprod};
		vy_sum = {{(SUM_W-ST_W){vel_y_q[ST_W-1]}}, vel_y_q}
		       + {{(SUM_W-ST_W-1){sprod[ST_W]}}, sprod};

		vel_sel = axis_q ? vel_y_q : vel_x_q;
		pos_sel = axis_q ? pos_y_q : pos_x_q;

		// |v| * dt / 2^30, truncated, then the velocity sign applied.
		pos_dlt = mag_neg_q ? SUM_W'(-{2'b00, acc_q[ACC_W-1:30]})
		                    : {2'b00, acc_q[ACC_W-1:30]};
		pos_sum = {{(SUM_W-ST_W){pos_sel[ST_W-1]}}, pos_sel} + pos_dlt;
		pos_new = sat48(pos_sum);

		// Per-axis displacement magnitude at 2^-16 m, capped to 31 bits.
		disp     = {pos_sel[ST_W-1], pos_sel} - {oldp_q[ST_W-1], oldp_q};
		disp_mag = disp[ST_W] ? (ST_W+1)'(-disp) : disp;
		disp_sh  = disp_mag[ST_W:4];
		emag     = (disp_sh[ST_W-4:EMAG_W] != '0) ? {EMAG_W{1'b1}} : disp_sh[EMAG_W-1:0];

		// One restoring square-root step: two radicand bits in, one root bit out.
		sq_rem   = {rem_q, sqn_q[PROD_W-1:PROD_W-2]};
		sq_trial = {2'b00, root_q, 2'b01};
		sq_take  = (sq_rem >= sq_trial);

		dist_sum = {1'b0, dist_q} + (ST_W+1)'(root_q);
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ua_q         <= idri_pkg::UA_IDLE;
			seen_first_q <= 1'b0;
			prior_q      <= '0;
			vel_x_q      <= '0;
			vel_y_q      <= '0;
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			heading_q    <= '0;
			dist_q       <= '0;
			axis_q       <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			ua_q <= ua_d;
			if (in_acc) begin
				prior_q      <= in_stamp;
				seen_first_q <= 1'b1;
			end
			case (uw.op)
				idri_pkg::OP_HEAD: heading_q <= heading_q + sprod[ST_W-1:0];
				idri_pkg::OP_VX:   vel_x_q   <= sat48(vx_sum);
				idri_pkg::OP_VY:   vel_y_q   <= sat48(vy_sum);
				idri_pkg::OP_POS: begin
					if (axis_q) begin
						pos_y_q <= pos_new;
					end else begin
						pos_x_q <= pos_new;
					end
				end
				idri_pkg::OP_STEP:  axis_q <= !axis_q;
				idri_pkg::OP_SQADD: cnt_q  <= idri_pkg::SQRT_LAST;
				idri_pkg::OP_SQRT:  cnt_q  <= cnt_q - idri_pkg::CNT_W'(1);
				idri_pkg::OP_DIST:  dist_q <= dist_sum[ST_W] ? {ST_W{1'b1}} : dist_sum[ST_W-1:0];
				default: begin
				end
			endcase
			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dt_q <= in_stamp - prior_q;
			ax_q <= in_ax;
			ay_q <= in_ay;
			wz_q <= in_wz;
		end
		prod_q     <= {{(PROD_W-MUL_W){1'b0}}, mul_a} * {{(PROD_W-MUL_W){1'b0}}, mul_b};
		prod_neg_q <= mul_neg;
		case (uw.op)
			idri_pkg::OP_LDMAG: begin
				mag_neg_q <= vel_sel[ST_W-1];
				mag_q     <= vel_sel[ST_W-1] ? ST_W'(-vel_sel) : vel_sel;
				acc_q     <= '0;
			end
			idri_pkg::OP_ACC:  acc_q <= {acc_q[ACC_W-CK_W-1:0], {CK_W{1'b0}}}
			                          + {{(ACC_W-PROD_W){1'b0}}, prod_q};
			idri_pkg::OP_POS:  oldp_q <= pos_sel;
			idri_pkg::OP_STEP: begin
				if (axis_q) begin
					ey_q <= emag;
				end else begin
					ex_q <= emag;
				end
			end
			idri_pkg::OP_SQLD: sqn_q <= prod_q;
			idri_pkg::OP_SQADD: begin
				sqn_q  <= sqn_q + prod_q;
				rem_q  <= '0;
				root_q <= '0;
			end
			idri_pkg::OP_SQRT: begin
				sqn_q <= {sqn_q[PROD_W-3:0], 2'b00};
				if (sq_take) begin
					rem_q  <= REM_W'(sq_rem - sq_trial);
					root_q <= {root_q[ROOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= sq_rem[REM_W-1:0];
					root_q <= {root_q[ROOT_W-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
		if (emit_en) begin
			out_px_q <= pos_x_q;
			out_py_q <= pos_y_q;
			out_hd_q <= heading_q;
			out_ds_q <= dist_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_ds_q, out_hd_q, out_py_q, out_px_q};

endmodule

`default_nettype wire

// File: sv/idri_checker.sv
// ----------------------------------------------------------------------------
// idri_checker
// Port-level checks of the IMU dead-reckoning integrator, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

module idri_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         s_axis_tvalid,
	input wire         s_axis_tready,
	input wire         m_axis_tvalid,
	input wire         m_axis_tready,
	input wire [191:0] m_axis_tdata
);

	logic       in_acc, out_acc;
	logic       seen_q;
	logic [2:0] owed_q;
	logic       have_dist_q;
	logic [47:0] last_dist_q;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// Results owed: every accepted sample except the first, minus results taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			owed_q      <= '0;
			have_dist_q <= 1'b0;
			last_dist_q <= '0;
		end else begin
			if (in_acc) begin
				seen_q <= 1'b1;
			end
			owed_q <= owed_q + 3'((in_acc && seen_q) ? 1 : 0) - 3'(out_acc ? 1 : 0);
			if (out_acc) begin
				have_dist_q <= 1'b1;
				last_dist_q <= m_axis_tdata[191:144];
			end
		end
	end

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed or dropped while stalled");

	// No result without a sample that calls for one; the first sample gives none.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> owed_q != 3'd0)
		else $error("result without a pending sample");

	// At most one result held and one sample in work.
	a_owed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		owed_q <= 3'd2)
		else $error("too many samples accepted ahead of results");

	// Total distance never decreases from one result to the next.
	a_dist_mono: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && have_dist_q |-> m_axis_tdata[191:144] >= last_dist_q)
		else $error("total distance decreased");

endmodule

bind imu_dead_reckoning_integrator_core idri_checker u_idri_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
